[rtl/assert_macros.svh]
// Assertion macros shared by the response header scanner RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[rtl/hrs_pkg.sv]
// Package for the HTTP response header scanner: sizes, codes, state and result types.
// No dependencies; used by hrs_step and http_response_header_scanner_top.
package hrs_pkg;

    // Sizes
    localparam int HeaderMax    = 1024;
    localparam int CountBits    = 40;
    localparam int HdrCntW      = $clog2(HeaderMax + 1);
    localparam int MinStatusHdr = 12;
    localparam int StatusDigits = 3;
    localparam int PrefixLen    = 5;
    localparam int NameLen      = 14;

    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

    // Action codes
    localparam logic [1:0] ActData  = 2'd0;
    localparam logic [1:0] ActClose = 2'd1;
    localparam logic [1:0] ActStart = 2'd2;

    // Event codes
    localparam logic [2:0] EvNone      = 3'd0;
    localparam logic [2:0] EvHdrOk     = 3'd1;
    localparam logic [2:0] EvRedirect  = 3'd2;
    localparam logic [2:0] EvFailure   = 3'd3;
    localparam logic [2:0] EvTooLarge  = 3'd4;
    localparam logic [2:0] EvBodyDone  = 3'd5;
    localparam logic [2:0] EvClosedHdr = 3'd6;

    // Response phase
    localparam logic [1:0] PhHeader     = 2'd0;
    localparam logic [1:0] PhBody       = 2'd1;
    localparam logic [1:0] PhDoneHdr    = 2'd2;
    localparam logic [1:0] PhDoneNoHdr  = 2'd3;

    // Status line scan
    localparam logic [1:0] SsSeek   = 2'd0;
    localparam logic [1:0] SsSpaces = 2'd1;
    localparam logic [1:0] SsDigits = 2'd2;
    localparam logic [1:0] SsEnd    = 2'd3;

    // Content-Length scan
    localparam logic [2:0] LsSearch   = 3'd0;
    localparam logic [2:0] LsName     = 3'd1;
    localparam logic [2:0] LsWs       = 3'd2;
    localparam logic [2:0] LsDigits   = 3'd3;
    localparam logic [2:0] LsFound    = 3'd4;
    localparam logic [2:0] LsNoDigits = 3'd5;

    localparam logic [2:0] PrefixGood = 3'd5;
    localparam logic [2:0] PrefixBad  = 3'd7;

    // Characters
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpZ   = 8'h5A;
    localparam logic [7:0] CaseGap = 8'h20;

    typedef struct packed {
        logic [1:0]           phase;
        logic [HdrCntW-1:0]   header_bytes;
        logic [1:0]           term_progress;
        logic [2:0]           prefix_pos;
        logic [1:0]           status_stage;
        logic [9:0]           status_accum;
        logic [1:0]           status_digits;
        logic                 at_line_start;
        logic [3:0]           name_pos;
        logic [2:0]           length_stage;
        logic [CountBits-1:0] length_accum;
        logic [CountBits-1:0] body_count;
    } state_t;

    typedef struct packed {
        logic                 body_valid;
        logic [7:0]           body_byte;
        logic [2:0]           event_res;
        logic [9:0]           status_code;
        logic                 status_valid;
        logic                 length_known;
        logic [CountBits-1:0] declared_length;
        logic [CountBits-1:0] saved_count;
    } result_t;

    localparam state_t StateReset = '{
        phase:         PhHeader,
        header_bytes:  '0,
        term_progress: 2'd0,
        prefix_pos:    3'd0,
        status_stage:  SsSeek,
        status_accum:  10'd0,
        status_digits: 2'd0,
        at_line_start: 1'b1,
        name_pos:      4'd0,
        length_stage:  LsSearch,
        length_accum:  '0,
        body_count:    '0
    };

    // "HTTP/" one character at a time
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "content-length" in lower case
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h6C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/hrs_step.sv]
// Per-byte next-state and result logic of the response header scanner.
// Depends on hrs_pkg (state_t, result_t, codes, character tables).
module hrs_step (
    input  hrs_pkg::state_t  st,
    input  logic [1:0]       action,
    input  logic [7:0]       data_byte,
    output hrs_pkg::state_t  st_next,
    output hrs_pkg::result_t res
);

    logic [7:0]                   lower;
    logic                         is_digit;
    logic [3:0]                   digit;
    logic [13:0]                  status_prod;
    logic [hrs_pkg::CountBits+3:0] len_prod;
    logic                         len_sat;
    logic [hrs_pkg::CountBits-1:0] len_stepped;
    logic [hrs_pkg::CountBits-1:0] body_inc;

    // Byte classification
    assign lower = (data_byte >= hrs_pkg::ChUpA && data_byte <= hrs_pkg::ChUpZ)
                 ? data_byte + hrs_pkg::CaseGap : data_byte;
    assign is_digit = data_byte >= hrs_pkg::ChZero && data_byte <= hrs_pkg::ChNine;
    assign digit    = data_byte[3:0];

    // Decimal accumulate: x*10 + d as shifts and adds
    assign status_prod = {1'b0, st.status_accum, 3'b000} + {3'b000, st.status_accum, 1'b0}
                       + {10'd0, digit};
    assign len_prod = {1'b0, st.length_accum, 3'b000} + {3'b000, st.length_accum, 1'b0}
                    + {{hrs_pkg::CountBits{1'b0}}, digit};
    assign len_sat     = len_prod > {4'd0, hrs_pkg::CountMax};
    assign len_stepped = len_sat ? hrs_pkg::CountMax : len_prod[hrs_pkg::CountBits-1:0];

    assign body_inc = (st.body_count != hrs_pkg::CountMax) ? st.body_count + 1'b1
                                                           : st.body_count;

    // Next state and event
    always_comb begin
        hrs_pkg::state_t ns;
        logic [2:0]      ev;
        logic            bv;
        logic [7:0]      bb;
        logic            hdr_end;
        logic            s_ok;
        logic            l_ok;
        logic            hd;

        ns      = st;
        ev      = hrs_pkg::EvNone;
        bv      = 1'b0;
        bb      = 8'd0;
        hdr_end = 1'b0;
        s_ok    = 1'b0;
        l_ok    = 1'b0;

        unique case (action)
            hrs_pkg::ActStart: begin
                ns = hrs_pkg::StateReset;
            end
            hrs_pkg::ActClose: begin
                if (st.phase == hrs_pkg::PhHeader) begin
                    ev       = hrs_pkg::EvClosedHdr;
                    ns.phase = hrs_pkg::PhDoneNoHdr;
                end else if (st.phase == hrs_pkg::PhBody) begin
                    ev       = hrs_pkg::EvBodyDone;
                    ns.phase = hrs_pkg::PhDoneHdr;
                end
            end
            hrs_pkg::ActData: begin
                if (st.phase == hrs_pkg::PhHeader) begin
                    if (st.header_bytes >= hrs_pkg::HdrCntW'(hrs_pkg::HeaderMax)) begin
                        // header overflow: stop scanning
                        ns.phase = hrs_pkg::PhDoneNoHdr;
                        ev       = hrs_pkg::EvTooLarge;
                    end else begin
                        ns.header_bytes = st.header_bytes + 1'b1;

                        // "HTTP/" prefix
                        if (st.prefix_pos < hrs_pkg::PrefixGood) begin
                            ns.prefix_pos = (data_byte == hrs_pkg::prefix_char(st.prefix_pos))
                                          ? st.prefix_pos + 3'd1 : hrs_pkg::PrefixBad;
                        end

                        // status code: first space, more spaces, three digits
                        if (st.status_stage == hrs_pkg::SsSeek) begin
                            if (data_byte == hrs_pkg::ChSpace) begin
                                ns.status_stage = hrs_pkg::SsSpaces;
                            end
                        end else if (st.status_stage == hrs_pkg::SsEnd) begin
                            ns.status_stage = hrs_pkg::SsEnd;
                        end else if (st.status_stage == hrs_pkg::SsSpaces &&
                                     data_byte == hrs_pkg::ChSpace) begin
                            ns.status_stage = hrs_pkg::SsSpaces;
                        end else if (is_digit &&
                                     st.status_digits < 2'(hrs_pkg::StatusDigits)) begin
                            ns.status_accum  = status_prod[9:0];
                            ns.status_digits = st.status_digits + 2'd1;
                            ns.status_stage  =
                                (st.status_digits == 2'(hrs_pkg::StatusDigits - 1))
                                ? hrs_pkg::SsEnd : hrs_pkg::SsDigits;
                        end else begin
                            ns.status_stage = hrs_pkg::SsEnd;
                        end

                        // Content-Length at a line start
                        unique case (st.length_stage)
                            hrs_pkg::LsSearch: begin
                                if (st.at_line_start && lower == hrs_pkg::name_char(4'd0)) begin
                                    ns.length_stage = hrs_pkg::LsName;
                                    ns.name_pos     = 4'd1;
                                end
                            end
                            hrs_pkg::LsName: begin
                                if (st.name_pos < 4'(hrs_pkg::NameLen)) begin
                                    if (lower == hrs_pkg::name_char(st.name_pos)) begin
                                        ns.name_pos = st.name_pos + 4'd1;
                                    end else begin
                                        ns.length_stage = hrs_pkg::LsSearch;
                                        ns.name_pos     = 4'd0;
                                    end
                                end else begin
                                    ns.length_stage = (data_byte == hrs_pkg::ChColon)
                                                    ? hrs_pkg::LsWs : hrs_pkg::LsSearch;
                                    ns.name_pos     = 4'd0;
                                end
                            end
                            hrs_pkg::LsWs: begin
                                if (data_byte == hrs_pkg::ChSpace ||
                                    data_byte == hrs_pkg::ChTab) begin
                                    ns.length_stage = hrs_pkg::LsWs;
                                end else if (is_digit) begin
                                    ns.length_accum =
                                        {{(hrs_pkg::CountBits-4){1'b0}}, digit};
                                    ns.length_stage = hrs_pkg::LsDigits;
                                end else begin
                                    ns.length_stage = hrs_pkg::LsNoDigits;
                                end
                            end
                            hrs_pkg::LsDigits: begin
                                if (is_digit) begin
                                    ns.length_accum = len_stepped;
                                end else begin
                                    ns.length_stage = hrs_pkg::LsFound;
                                end
                            end
                            default: begin
                                ns.length_stage = st.length_stage;
                            end
                        endcase
                        ns.at_line_start = (data_byte == hrs_pkg::ChLf);

                        // CR LF CR LF tracker
                        if (data_byte == hrs_pkg::ChCr) begin
                            ns.term_progress = (st.term_progress == 2'd2) ? 2'd3 : 2'd1;
                        end else if (data_byte == hrs_pkg::ChLf) begin
                            hdr_end          = (st.term_progress == 2'd3);
                            ns.term_progress = (st.term_progress == 2'd1) ? 2'd2 : 2'd0;
                        end else begin
                            ns.term_progress = 2'd0;
                        end

                        // header end: classify the status
                        if (hdr_end) begin
                            ns.phase = hrs_pkg::PhDoneHdr;
                            s_ok = ns.prefix_pos == hrs_pkg::PrefixGood &&
                                   ns.header_bytes >= hrs_pkg::HdrCntW'(hrs_pkg::MinStatusHdr) &&
                                   ns.status_digits == 2'(hrs_pkg::StatusDigits);
                            l_ok = ns.length_stage == hrs_pkg::LsDigits ||
                                   ns.length_stage == hrs_pkg::LsFound;
                            if (s_ok && ns.status_accum >= 10'd200 &&
                                ns.status_accum < 10'd300) begin
                                ev = hrs_pkg::EvHdrOk;
                                if (!(l_ok && ns.length_accum == '0)) begin
                                    ns.phase = hrs_pkg::PhBody;
                                end
                            end else if (s_ok && ns.status_accum >= 10'd300 &&
                                         ns.status_accum < 10'd400) begin
                                ev = hrs_pkg::EvRedirect;
                            end else begin
                                ev = hrs_pkg::EvFailure;
                            end
                        end
                    end
                end else if (st.phase == hrs_pkg::PhBody) begin
                    // body pass-through and length check
                    bv            = 1'b1;
                    bb            = data_byte;
                    ns.body_count = body_inc;
                    if ((st.length_stage == hrs_pkg::LsDigits ||
                         st.length_stage == hrs_pkg::LsFound) &&
                        body_inc >= st.length_accum) begin
                        ev       = hrs_pkg::EvBodyDone;
                        ns.phase = hrs_pkg::PhDoneHdr;
                    end
                end
            end
            default: begin
                ns = st;
            end
        endcase

        // result fields from the updated state
        hd   = ns.phase == hrs_pkg::PhBody || ns.phase == hrs_pkg::PhDoneHdr;
        s_ok = hd && ns.prefix_pos == hrs_pkg::PrefixGood &&
               ns.header_bytes >= hrs_pkg::HdrCntW'(hrs_pkg::MinStatusHdr) &&
               ns.status_digits == 2'(hrs_pkg::StatusDigits);
        l_ok = hd && (ns.length_stage == hrs_pkg::LsDigits ||
                      ns.length_stage == hrs_pkg::LsFound);

        st_next             = ns;
        res.body_valid      = bv;
        res.body_byte       = bb;
        res.event_res       = ev;
        res.status_code     = s_ok ? ns.status_accum : 10'd0;
        res.status_valid    = s_ok;
        res.length_known    = l_ok;
        res.declared_length = l_ok ? ns.length_accum : '0;
        res.saved_count     = ns.body_count;
    end

endmodule

[rtl/http_response_header_scanner_top.sv]
// Top level of the HTTP response header scanner: input register, state, result register.
// Depends on hrs_pkg, hrs_step and assert_macros.svh.
//
//  channel  ports  direction  contents
//  input    s_*    in         action, data_byte
//  result   m_*    out        body flag and byte, event, status, length, body count
//
// One transaction in, one result out. The byte is registered in the input
// register, then one pass of the byte-step logic updates the scan state and
// loads the result register. A new byte is taken every cycle while results drain.
// aresetn (synchronous, active low) empties both registers and restores the scan state.
// A stalled result holds the pipeline; s_ready follows m_ready in the same cycle.
`include "assert_macros.svh"

module http_response_header_scanner_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_action,
    input  logic [7:0]                    s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_body_valid,
    output logic [7:0]                    m_body_byte,
    output logic [2:0]                    m_event_res,
    output logic [9:0]                    m_status_code,
    output logic                          m_status_valid,
    output logic                          m_length_known,
    output logic [hrs_pkg::CountBits-1:0] m_declared_length,
    output logic [hrs_pkg::CountBits-1:0] m_saved_count
);

    logic             in_valid_reg;
    logic [1:0]       in_action_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    hrs_pkg::result_t out_reg;
    hrs_pkg::state_t  state_reg;
    hrs_pkg::state_t  state_next;
    hrs_pkg::result_t res_next;
    logic             advance;
    logic             s_fire;

    // Handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_action_reg <= s_action;
            in_byte_reg   <= s_data_byte;
        end
    end

    // Byte step
    hrs_step u_step (
        .st        (state_reg),
        .action    (in_action_reg),
        .data_byte (in_byte_reg),
        .st_next   (state_next),
        .res       (res_next)
    );

    // Scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hrs_pkg::StateReset;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_body_valid      = out_reg.body_valid;
    assign m_body_byte       = out_reg.body_byte;
    assign m_event_res       = out_reg.event_res;
    assign m_status_code     = out_reg.status_code;
    assign m_status_valid    = out_reg.status_valid;
    assign m_length_known    = out_reg.length_known;
    assign m_declared_length = out_reg.declared_length;
    assign m_saved_count     = out_reg.saved_count;

    // Checks
    `ASSERT_IMPL(a_body_event, aclk, aresetn, out_valid_reg && out_reg.body_valid, out_reg.event_res == hrs_pkg::EvNone || out_reg.event_res == hrs_pkg::EvBodyDone)
    `ASSERT_IMPL(a_status_zero, aclk, aresetn, out_valid_reg && !out_reg.status_valid, out_reg.status_code == 10'd0)
    `ASSERT_IMPL(a_length_zero, aclk, aresetn, out_valid_reg && !out_reg.length_known, out_reg.declared_length == '0)
    `ASSERT_IMPL(a_body_status, aclk, aresetn, state_reg.phase == hrs_pkg::PhBody, state_reg.prefix_pos == hrs_pkg::PrefixGood && state_reg.status_digits == 2'(hrs_pkg::StatusDigits))
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, out_valid_reg && !m_ready, out_valid_reg && $stable(out_reg))

endmodule
